[rtl/core/pe_r2f_pkg.sv]
// Package: shared types, codes and helpers for the section-table range resolver.
`timescale 1ns / 1ps
`default_nettype none
package pe_r2f_pkg;

  localparam int MAX_SECTIONS_DEF = 96;
  localparam int SLOT_W           = 7;
  localparam int HITS_W           = 2;
  localparam int CFG_IDX_W        = 3;
  localparam int CNT_W            = 7;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_SIZE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_SIZE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FILE_LENGTH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SECTION_COUNT = 3'd3;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_REJECTED   = 3'd1,
    ST_OVERFLOW   = 3'd2,
    ST_NOT_EXEC   = 3'd3,
    ST_NOT_BACKED = 3'd4,
    ST_BAD_TABLE  = 3'd5
  } status_t;

  typedef struct packed {
    logic              kind;
    logic [SLOT_W-1:0] entry_slot;
    logic [31:0]       entry_virtual_address;
    logic [31:0]       entry_virtual_size;
    logic [31:0]       entry_raw_offset;
    logic [31:0]       entry_raw_size;
    logic              entry_executable;
    logic [31:0]       query_address;
    logic [31:0]       query_length;
    logic              need_executable;
  } in_item_t;

  typedef struct packed {
    status_t           status;
    logic [31:0]       range_off;
    logic [SLOT_W-1:0] matched_section;
  } out_item_t;

  typedef struct packed {
    logic [31:0] vaddr;
    logic [31:0] vsize;
    logic [31:0] raw_off;
    logic [31:0] raw_len;
    logic        exec;
  } entry_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] slot;
    entry_t            ent;
  } wr_t;

  // search token walking the cell row
  typedef struct packed {
    logic              vld;
    logic [31:0]       addr;
    logic [HITS_W-1:0] hits;
    logic [SLOT_W-1:0] slot;
    logic [31:0]       delta;
    logic [31:0]       raw_off;
    logic [31:0]       raw_len;
    logic              exec;
  } tok_t;

  // start <= limit and len <= limit - start
  function automatic logic fits_within(logic [32:0] start, logic [31:0] len,
                                       logic [31:0] limit);
    logic [32:0] room;
    room = {1'b0, limit} - start;
    return (start <= {1'b0, limit}) && ({1'b0, len} <= room);
  endfunction

endpackage
`default_nettype wire

[rtl/core/pe_r2f_cell.sv]
// One cell: holds a section entry and checks the passing token against it.
`timescale 1ns / 1ps
`default_nettype none
module pe_r2f_cell #(
  parameter int IDX = 0
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [pe_r2f_pkg::CNT_W-1:0] sect_cnt,
  input  wire pe_r2f_pkg::wr_t             wr,
  input  wire pe_r2f_pkg::tok_t            tok_in,
  output pe_r2f_pkg::tok_t                 tok_out
);
  import pe_r2f_pkg::*;

  localparam logic [8:0] IDX_V = 9'(IDX);

  entry_t      ent_r;
  tok_t        tok_r;
  tok_t        tok_nxt;
  logic        wr_hit;
  logic        active;
  logic [31:0] span;
  logic [31:0] diff;
  logic        match;

  assign wr_hit = wr.en && (IDX < (2 ** SLOT_W)) && (wr.slot == SLOT_W'(IDX));
  assign active = {2'b00, sect_cnt} > IDX_V;
  assign span   = (ent_r.raw_len > ent_r.vsize) ? ent_r.raw_len : ent_r.vsize;
  assign diff   = tok_in.addr - ent_r.vaddr;
  assign match  = tok_in.vld && active && (span != 32'd0) &&
                  (tok_in.addr >= ent_r.vaddr) && (diff < span);

  always_comb begin
    tok_nxt = tok_in;
    if (match) begin
      if (tok_in.hits == '0) begin
        tok_nxt.slot    = SLOT_W'(IDX);
        tok_nxt.delta   = diff;
        tok_nxt.raw_off = ent_r.raw_off;
        tok_nxt.raw_len = ent_r.raw_len;
        tok_nxt.exec    = ent_r.exec;
      end
      if (tok_in.hits != HITS_W'(2)) begin
        tok_nxt.hits = tok_in.hits + HITS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_hit) begin
      ent_r <= wr.ent;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule
`default_nettype wire

[rtl/core/pe_r2f_chain.sv]
// Row of section cells; the search token moves one cell per cycle.
`timescale 1ns / 1ps
`default_nettype none
module pe_r2f_chain #(
  parameter int MAX_SECTIONS = pe_r2f_pkg::MAX_SECTIONS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [pe_r2f_pkg::CNT_W-1:0] sect_cnt,
  input  wire pe_r2f_pkg::wr_t             wr,
  input  wire pe_r2f_pkg::tok_t            tok_head,
  output pe_r2f_pkg::tok_t                 tok_tail
);
  import pe_r2f_pkg::*;

  tok_t tok [MAX_SECTIONS+1];

  assign tok[0]   = tok_head;
  assign tok_tail = tok[MAX_SECTIONS];

  for (genvar i = 0; i < MAX_SECTIONS; i++) begin : g_cell
    pe_r2f_cell #(
      .IDX (i)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .sect_cnt (sect_cnt),
      .wr       (wr),
      .tok_in   (tok[i]),
      .tok_out  (tok[i+1])
    );
  end

endmodule
`default_nettype wire

[rtl/core/pe_rva_to_file_offset.sv]
// Top level: range resolver over a loaded section table; a load writes its entry, no result.
// Query: header, rejected and overflow results are decided in S_PRE and sent from S_EMIT;
// section queries walk a token along the cell row in S_SCAN, then go through S_POST1 and,
// when the file bound is checked, S_POST2. One query in flight; items are taken in S_IDLE.
// Synchronous reset clears control state and the configuration registers;
// section entries hold no defined value until loaded.
`timescale 1ns / 1ps
`default_nettype none
module pe_rva_to_file_offset #(
  parameter int MAX_SECTIONS = pe_r2f_pkg::MAX_SECTIONS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire pe_r2f_pkg::in_item_t            in_item,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output pe_r2f_pkg::out_item_t                out_item,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [pe_r2f_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]                     cfg_data
);
  import pe_r2f_pkg::*;

  localparam logic [SLOT_W-1:0] NONE = SLOT_W'(MAX_SECTIONS);

  typedef enum logic [2:0] {
    S_IDLE, S_PRE, S_SCAN, S_POST1, S_POST2, S_EMIT
  } state_t;

  state_t            state_r, state_nxt;
  logic [31:0]       image_size_r, header_size_r, file_length_r;
  logic [CNT_W-1:0]  sect_cnt_r;
  logic [31:0]       addr_r, len_r;
  logic              need_x_r;
  tok_t              tok_r, tok_nxt;
  logic [32:0]       foff_r, foff_nxt;
  out_item_t         res_r, res_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_r, out_nxt;
  logic              in_acc;
  wr_t               wr;
  tok_t              launch;
  tok_t              tail;

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  assign wr.en          = in_acc && (in_item.kind == KIND_LOAD);
  assign wr.slot        = in_item.entry_slot;
  assign wr.ent.vaddr   = in_item.entry_virtual_address;
  assign wr.ent.vsize   = in_item.entry_virtual_size;
  assign wr.ent.raw_off = in_item.entry_raw_offset;
  assign wr.ent.raw_len = in_item.entry_raw_size;
  assign wr.ent.exec    = in_item.entry_executable;

  pe_r2f_chain #(
    .MAX_SECTIONS (MAX_SECTIONS)
  ) u_chain (
    .clk      (clk),
    .rst_n    (rst_n),
    .sect_cnt (sect_cnt_r),
    .wr       (wr),
    .tok_head (launch),
    .tok_tail (tail)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_size_r  <= '0;
      header_size_r <= '0;
      file_length_r <= '0;
      sect_cnt_r    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_IMAGE_SIZE:    image_size_r  <= cfg_data;
        REG_HEADER_SIZE:   header_size_r <= cfg_data;
        REG_FILE_LENGTH:   file_length_r <= cfg_data;
        REG_SECTION_COUNT: sect_cnt_r    <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && (in_item.kind == KIND_QUERY)) begin
      addr_r   <= in_item.query_address;
      len_r    <= in_item.query_length;
      need_x_r <= in_item.need_executable;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    tok_nxt       = tok_r;
    foff_nxt      = foff_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    launch        = '0;
    launch.addr   = addr_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc && (in_item.kind == KIND_QUERY)) begin
          state_nxt = S_PRE;
        end
      end
      S_PRE: begin
        res_nxt.status          = ST_OK;
        res_nxt.range_off       = '0;
        res_nxt.matched_section = NONE;
        state_nxt               = S_EMIT;
        priority if ((len_r == '0) || (image_size_r == '0) || (header_size_r == '0)) begin
          res_nxt.status = ST_REJECTED;
        end else if (!fits_within({1'b0, addr_r}, len_r, image_size_r)) begin
          res_nxt.status = ST_OVERFLOW;
        end else if (addr_r < header_size_r) begin
          priority if (need_x_r) begin
            res_nxt.status = ST_NOT_EXEC;
          end else if (!fits_within({1'b0, addr_r}, len_r, header_size_r) ||
                       !fits_within({1'b0, addr_r}, len_r, file_length_r)) begin
            res_nxt.status = ST_NOT_BACKED;
          end else begin
            res_nxt.range_off = addr_r;
          end
        end else begin
          launch.vld = 1'b1;
          state_nxt  = S_SCAN;
        end
      end
      S_SCAN: begin
        if (tail.vld) begin
          tok_nxt   = tail;
          state_nxt = S_POST1;
        end
      end
      S_POST1: begin
        res_nxt.status          = ST_NOT_BACKED;
        res_nxt.range_off       = '0;
        res_nxt.matched_section = NONE;
        foff_nxt                = {1'b0, tok_r.raw_off} + {1'b0, tok_r.delta};
        state_nxt               = S_EMIT;
        priority if (tok_r.hits > HITS_W'(1)) begin
          res_nxt.status = ST_BAD_TABLE;
        end else if (tok_r.hits == '0) begin
          res_nxt.status = ST_NOT_BACKED;
        end else if (need_x_r && !tok_r.exec) begin
          res_nxt.status = ST_NOT_EXEC;
        end else if (!fits_within({1'b0, tok_r.delta}, len_r, tok_r.raw_len)) begin
          res_nxt.status = ST_NOT_BACKED;
        end else begin
          state_nxt = S_POST2;
        end
      end
      S_POST2: begin
        state_nxt = S_EMIT;
        if (fits_within(foff_r, len_r, file_length_r)) begin
          res_nxt.status          = ST_OK;
          res_nxt.range_off       = foff_r[31:0];
          res_nxt.matched_section = tok_r.slot;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_nxt       = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    tok_r  <= tok_nxt;
    foff_r <= foff_nxt;
    res_r  <= res_nxt;
    out_r  <= out_nxt;
  end

endmodule
`default_nettype wire
